@@ src/sus_pkg.sv @@
// ----------------------------------------------------------------------------
// sus_pkg
// Shared types, defaults and helpers for the smallest unformable subset sum
// block.
// ----------------------------------------------------------------------------
package sus_pkg;

	localparam int VALUE_MAX_DEF  = 255;
	localparam int REACH_BITS_DEF = 4096;
	localparam int WORD_BITS_DEF  = 64;

	localparam int VALUE_W  = 8;
	localparam int ANSWER_W = 13;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_last;
	} item_t;

	typedef struct packed {
		logic [ANSWER_W-1:0] first_unformed;
		logic                overflow;
	} result_t;

	// Per-word controls for the merge unit.
	typedef struct packed {
		logic set_bit;    // this word holds the element's own bit
		logic last_word;  // trim bits beyond the bitset capacity
	} merge_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_WALK,
		ST_PREP,
		ST_SRCH_RD,
		ST_SRCH_CHK,
		ST_BITS,
		ST_FIN
	} state_t;

	// Index of the lowest set bit of an 8-bit chunk.
	function automatic logic [2:0] lowest_one8(input logic [7:0] bits);
		logic [2:0] idx;
		idx = '0;
		for (int i = 7; i >= 0; i--) begin
			if (bits[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

endpackage

@@ src/sus_mem.sv @@
// ----------------------------------------------------------------------------
// sus_mem
// Reachability word store: one write port, two registered read ports and
// one valid bit per word, so the whole store reads as zero after a clear.
// ----------------------------------------------------------------------------
module sus_mem #(
	parameter int WORD_BITS = 64,
	parameter int WORDS     = 64,
	parameter int ADDR_W    = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [ADDR_W-1:0]    raddr_a,
	input  logic [ADDR_W-1:0]    raddr_b,
	output logic [WORD_BITS-1:0] rdata_a,
	output logic [WORD_BITS-1:0] rdata_b
);

	logic [WORD_BITS-1:0] mem_q [WORDS];
	logic [WORD_BITS-1:0] rd_a_q;
	logic [WORD_BITS-1:0] rd_b_q;
	logic [WORDS-1:0]     vld_q;
	logic                 vld_a_q;
	logic                 vld_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			vld_a_q <= vld_q[raddr_a];
			vld_b_q <= vld_q[raddr_b];
		end
	end

	// A word never written since the last clear reads as all zero.
	assign rdata_a = vld_a_q ? rd_a_q : '0;
	assign rdata_b = vld_b_q ? rd_b_q : '0;

endmodule

@@ src/sus_merge.sv @@
// ----------------------------------------------------------------------------
// sus_merge
// Shared shift unit: shifts a pair of source words left by the in-word
// offset of the element and merges the upper word into the destination.
// ----------------------------------------------------------------------------
module sus_merge
	import sus_pkg::*;
#(
	parameter int WORD_BITS = 64,
	parameter int LAST_BITS = 64,
	parameter int SHIFT_W   = 6
) (
	input  logic [WORD_BITS-1:0] old_word,
	input  logic [WORD_BITS-1:0] src_hi,
	input  logic [WORD_BITS-1:0] src_lo,
	input  logic [SHIFT_W-1:0]   shamt,
	input  merge_ctl_t           ctl,
	output logic [WORD_BITS-1:0] new_word
);

	localparam logic [WORD_BITS-1:0] ALL_ONES  = {WORD_BITS{1'b1}};
	localparam logic [WORD_BITS-1:0] LAST_MASK = ALL_ONES >> (WORD_BITS - LAST_BITS);

	logic [2*WORD_BITS-1:0] pair_sh;
	logic [WORD_BITS-1:0]   own_bit;
	logic [WORD_BITS-1:0]   keep;

	always_comb begin
		pair_sh  = {src_hi, src_lo} << shamt;
		own_bit  = ctl.set_bit ? (WORD_BITS'(1) << shamt) : '0;
		keep     = ctl.last_word ? LAST_MASK : ALL_ONES;
		new_word = (old_word | pair_sh[2*WORD_BITS-1:WORD_BITS] | own_bit) & keep;
	end

endmodule

@@ src/smallest_unformable_subset_sum.sv @@
// ----------------------------------------------------------------------------
// smallest_unformable_subset_sum
// Loads a set of positive integers one per transaction and, on the closing
// element, reports the smallest integer from the set minimum upward that no
// non-empty subset sums to, capped at the bitset capacity.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  item    | in        | item_valid/item_stall | value, is_last
//  result  | out       | result_valid/result_stall | first_unformed, overflow
//
// A nonzero element is accepted, then a setup state loads the walk counters
// and a walk passes over the reachability store, one word per cycle through
// the shared merge unit. The closing element adds a setup state, a read and
// a check per word searched (plus a final read when no word in the window
// holds a gap), a bit scan and a hand-off of the result.
// After reset the store reads as empty at once; no clearing pass is needed.
// item_stall is high whenever an element is being worked on; a result that
// waits on result_stall only holds the block once the next result is ready.
//
// The reachability set lives in a word store. For an element v = q*W + r the
// destination word d gets the pair {word d-q, word d-q-1} shifted left by r.
// Words are walked from the top down, so every source word is read before it
// can be overwritten. Port B streams the lower source word, the upper one is
// the word that port B returned in the previous cycle, and port A returns
// the old destination word. The word size is a power of two, so the
// quotient and the remainder of v are its upper and lower bits; a setup
// state ahead of the walk loads the walk counters.
//
// The search walks words from the bottom, masks each one to the window
// [minimum, min(total, capacity-1)], and on the first word with a zero bit
// scans that word eight bits per cycle.
// ----------------------------------------------------------------------------
module smallest_unformable_subset_sum
	import sus_pkg::*;
#(
	parameter int VALUE_MAX  = VALUE_MAX_DEF,
	parameter int REACH_BITS = REACH_BITS_DEF,
	parameter int WORD_BITS  = WORD_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int WB        = WORD_BITS;
	localparam int WC        = (REACH_BITS + WB - 1) / WB;
	localparam int AW        = (WC > 1) ? $clog2(WC) : 1;
	localparam int RW        = $clog2(WB);
	localparam int LAST_BITS = REACH_BITS - (WC - 1) * WB;
	localparam int TW        = $clog2(REACH_BITS + 1);
	localparam int PW        = $clog2(WC * WB + 512);
	localparam int SIW       = AW + 10;
	localparam int SW        = $clog2(WC + 2);
	localparam int VMAX_CLIP = (VALUE_MAX > 255) ? 255 : VALUE_MAX;

	localparam logic [VALUE_W-1:0] VMAX_L   = VALUE_W'(VMAX_CLIP);
	localparam logic [SW-1:0]      WC_L     = SW'(WC);
	localparam logic [SW-1:0]      WALK_END = SW'(WC + 1);
	localparam logic [AW-1:0]      TOP_WORD = AW'(WC - 1);
	localparam logic [TW-1:0]      CAP_L    = TW'(REACH_BITS);
	localparam logic [TW-1:0]      CAP_M1   = TW'(REACH_BITS - 1);
	localparam logic [WB-1:0]      ONES     = {WB{1'b1}};

	// Control and per-set state.
	state_t              state_q, state_d;
	logic                last_q;
	logic [VALUE_W-1:0]  smallest_q;
	logic [TW-1:0]       total_q;
	logic                ovf_q;

	// Element update.
	logic [RW-1:0]       rem_q;
	logic [VALUE_W-1:0]  quo_q;
	logic [SW-1:0]       step_q;
	logic signed [SIW-1:0] src_q;
	logic                wr_s1;
	logic                src_ok_s1;
	logic [AW-1:0]       dst_s1;
	logic [WB-1:0]       srcprev_q;

	// Search.
	logic [AW:0]         sw_q;
	logic [PW-1:0]       base_q;
	logic [WB-1:0]       z_q;
	logic [TW-1:0]       ans_q;

	// Output register.
	logic                res_valid_q;
	result_t             res_q;

	// Combinational signals.
	logic                item_fire;
	logic [VALUE_W-1:0]  v_sat;
	logic [PW-1:0]       sum_p;
	logic                sum_ovf;
	logic [AW-1:0]       dst_idx;
	logic                issue_dst;
	logic                src_ok;
	logic [TW-1:0]       top_t;
	logic [TW-1:0]       dflt_ans;
	logic [PW-1:0]       sm_p;
	logic [PW-1:0]       top_p;
	logic [PW-1:0]       lo_off;
	logic [PW-1:0]       hi_off;
	logic [WB-1:0]       lo_mask;
	logic [WB-1:0]       hi_mask;
	logic [WB-1:0]       z_chk;
	logic                found8;
	logic                fin_go;
	logic                res_take;
	logic [AW-1:0]       raddr_a;
	logic [WB-1:0]       rdata_a;
	logic [WB-1:0]       rdata_b;
	logic [WB-1:0]       src_lo;
	logic [WB-1:0]       merged;
	merge_ctl_t          mctl;

	assign item_stall   = (state_q != ST_IDLE);
	assign item_fire    = item_valid && !item_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign res_take     = res_valid_q && !result_stall;
	assign fin_go       = (state_q == ST_FIN) && (!res_valid_q || !result_stall);

	always_comb begin
		v_sat   = (item.value > VMAX_L) ? VMAX_L : item.value;
		sum_p   = PW'(total_q) + PW'(v_sat);
		sum_ovf = (sum_p >= PW'(REACH_BITS));

		// Walk addressing: the first destination word is issued in the cycle
		// after the first source word.
		dst_idx   = AW'(WC_L - step_q);
		issue_dst = (step_q != '0) && (step_q <= WC_L);
		src_ok    = !src_q[SIW-1];

		// Search window and fallback answer.
		top_t    = (total_q > CAP_M1) ? CAP_M1 : total_q;
		dflt_ans = ovf_q ? CAP_L : (total_q + TW'(1));
		sm_p     = PW'(smallest_q);
		top_p    = PW'(top_t);
		lo_off   = sm_p - base_q;
		hi_off   = top_p - base_q;
		if (sm_p <= base_q) begin
			lo_mask = ONES;
		end else if (lo_off < PW'(WB)) begin
			lo_mask = ONES << RW'(lo_off);
		end else begin
			lo_mask = '0;
		end
		if (hi_off < PW'(WB)) begin
			hi_mask = ONES >> RW'(PW'(WB - 1) - hi_off);
		end else begin
			hi_mask = ONES;
		end
		z_chk  = ~rdata_a & lo_mask & hi_mask;
		found8 = (z_q[7:0] != '0);

		raddr_a = (state_q == ST_WALK) ? dst_idx : sw_q[AW-1:0];

		src_lo         = src_ok_s1 ? rdata_b : '0;
		mctl.set_bit   = (PW'(dst_s1) == PW'(quo_q));
		mctl.last_word = (dst_s1 == TOP_WORD);
	end

	sus_mem #(
		.WORD_BITS (WB),
		.WORDS     (WC),
		.ADDR_W    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (fin_go),
		.we      (wr_s1),
		.waddr   (dst_s1),
		.wdata   (merged),
		.raddr_a (raddr_a),
		.raddr_b (src_q[AW-1:0]),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	sus_merge #(
		.WORD_BITS (WB),
		.LAST_BITS (LAST_BITS),
		.SHIFT_W   (RW)
	) u_merge (
		.old_word (rdata_a),
		.src_hi   (srcprev_q),
		.src_lo   (src_lo),
		.shamt    (rem_q),
		.ctl      (mctl),
		.new_word (merged)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_fire) begin
					if (v_sat != '0) begin
						state_d = ST_DIV;
					end else if (item.is_last) begin
						state_d = ST_PREP;
					end
				end
			end
			ST_DIV: begin
				state_d = ST_WALK;
			end
			ST_WALK: begin
				if (step_q == WALK_END) begin
					state_d = last_q ? ST_PREP : ST_IDLE;
				end
			end
			ST_PREP: begin
				state_d = (sm_p > top_p) ? ST_FIN : ST_SRCH_RD;
			end
			ST_SRCH_RD: begin
				state_d = (base_q > top_p) ? ST_FIN : ST_SRCH_CHK;
			end
			ST_SRCH_CHK: begin
				state_d = (z_chk != '0) ? ST_BITS : ST_SRCH_RD;
			end
			ST_BITS: begin
				if (found8) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smallest_q  <= VMAX_L;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			wr_s1       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			wr_s1 <= (state_q == ST_WALK) && issue_dst;

			if (item_fire) begin
				last_q <= item.is_last;
				rem_q  <= v_sat[RW-1:0];
				quo_q  <= v_sat >> RW;
				if (v_sat != '0) begin
					if (v_sat < smallest_q) begin
						smallest_q <= v_sat;
					end
					if (sum_ovf) begin
						ovf_q   <= 1'b1;
						total_q <= CAP_L;
					end else begin
						total_q <= TW'(sum_p);
					end
				end
			end

			if (state_q == ST_DIV) begin
				step_q <= '0;
				src_q  <= SIW'(WC - 1) - SIW'(quo_q);
			end

			if (state_q == ST_WALK) begin
				step_q    <= step_q + SW'(1);
				src_q     <= src_q - SIW'(1);
				dst_s1    <= dst_idx;
				src_ok_s1 <= src_ok;
				srcprev_q <= src_lo;
			end

			if (state_q == ST_PREP) begin
				sw_q   <= '0;
				base_q <= '0;
				if (sm_p > top_p) begin
					ans_q <= dflt_ans;
				end
			end

			if (state_q == ST_SRCH_RD && base_q > top_p) begin
				ans_q <= dflt_ans;
			end

			if (state_q == ST_SRCH_CHK) begin
				if (z_chk != '0) begin
					z_q <= z_chk;
				end else begin
					sw_q   <= sw_q + (AW + 1)'(1);
					base_q <= base_q + PW'(WB);
				end
			end

			if (state_q == ST_BITS) begin
				if (found8) begin
					ans_q <= TW'(base_q + PW'(lowest_one8(z_q[7:0])));
				end else begin
					z_q    <= z_q >> 8;
					base_q <= base_q + PW'(8);
				end
			end

			// Hand off the result and start a fresh set.
			if (fin_go) begin
				res_q.first_unformed <= ANSWER_W'(ans_q);
				res_q.overflow       <= ovf_q;
				res_valid_q          <= 1'b1;
				smallest_q           <= VMAX_L;
				total_q              <= '0;
				ovf_q                <= 1'b0;
			end else if (res_take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// The store is written only by the word walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> (state_q == ST_WALK))
		else $error("store written outside the word walk");

	// A new result appears only out of the hand-off state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the hand-off state");

	// After a hand-off the per-set state is back at its start values.
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> (state_q == ST_IDLE && total_q == '0 && !ovf_q && smallest_q == VMAX_L))
		else $error("set state not cleared after a result");

	// Every word check follows a word read.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH_CHK) |-> $past(state_q == ST_SRCH_RD))
		else $error("search check without a preceding read");
`endif

endmodule

@@ verif/unformed_sum_checker.sv @@
// ----------------------------------------------------------------------------
// unformed_sum_checker
// Watches both channels of the subset sum block, keeps its own reachability
// set for the set being loaded, and compares every result with the answer
// it expects.
// ----------------------------------------------------------------------------
module unformed_sum_checker
	import sus_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_stall,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      fail_count,
	output int      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned REACH = REACH_BITS_DEF;

	// Bit s is set when some non-empty subset of the elements so far sums to s.
	logic [REACH-1:0] reach_set;
	int unsigned      set_min;
	int unsigned      set_total;
	logic             set_ovf;
	result_t          answer_q[$];
	result_t          want;

	task automatic clear_set();
		reach_set = '0;
		set_min   = VALUE_MAX_DEF;
		set_total = 0;
		set_ovf   = 1'b0;
	endtask

	task automatic absorb_element(input int unsigned v);
		int unsigned e;
		e = (v > VALUE_MAX_DEF) ? VALUE_MAX_DEF : v;
		reach_set = reach_set | (reach_set << e);
		reach_set[e] = 1'b1;
		if (e < set_min) begin
			set_min = e;
		end
		if (set_total + e >= REACH) begin
			set_ovf   = 1'b1;
			set_total = REACH;
		end else begin
			set_total = set_total + e;
		end
	endtask

	// Smallest sum in [minimum, min(total, capacity-1)] that is missing.
	function automatic result_t closing_answer();
		int unsigned window_top;
		int unsigned ans;
		bit          found;
		result_t     r;
		window_top = (set_total > REACH - 1) ? REACH - 1 : set_total;
		ans        = set_ovf ? REACH : set_total + 1;
		found      = 1'b0;
		for (int unsigned i = set_min; i <= window_top; i++) begin
			if (!found && !reach_set[i]) begin
				ans   = i;
				found = 1'b1;
			end
		end
		r.first_unformed = ANSWER_W'(ans);
		r.overflow       = set_ovf;
		return r;
	endfunction

	initial begin
		clear_set();
		fail_count = 0;
		pending    = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_set();
			answer_q.delete();
			pending = 0;
		end else begin
			// Results are checked first: one accepted at this edge always
			// belongs to a set that was closed at an earlier edge.
			if (result_valid && !result_stall) begin
				if (answer_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: unexpected result first_unformed=%0d overflow=%0b",
							$realtime, result.first_unformed, result.overflow);
					end
				end else begin
					want = answer_q.pop_front();
					if (result.first_unformed !== want.first_unformed ||
						result.overflow !== want.overflow) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch expected first_unformed=%0d overflow=%0b,",
								$realtime, want.first_unformed, want.overflow,
								" got first_unformed=%0d overflow=%0b",
								result.first_unformed, result.overflow);
						end
					end
				end
			end
			if (item_valid && !item_stall) begin
				if (item.value != '0) begin
					absorb_element(item.value);
				end
				if (item.is_last) begin
					answer_q.insert(answer_q.size(), closing_answer());
					clear_set();
				end
			end
			pending = answer_q.size();
		end
	end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the smallest unformable subset sum block. Sends
// directed sets and then random sets of many shapes, idles both channels at
// random and leaves all prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module tb
	import sus_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// A transaction with no acceptance on either channel for this many cycles
	// means the block is stuck. The slowest correct stretch is one element
	// walk plus a closing search, the longest sender gap and the longest
	// receiver stall.
	localparam int IDLE_LIMIT = 4000;
	// Time left after the last result so that any stray extra result shows.
	localparam int END_WAIT   = 400;
	localparam int ITEM_GOAL  = 1400;
	localparam int unsigned REACH = REACH_BITS_DEF;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int fail_count;
	int pending;
	int idle_cycles  = 0;
	int items_sent   = 0;
	bit steady       = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	smallest_unformable_subset_sum u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	unformed_sum_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// The watchdog restarts on every accepted transaction on either channel.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Gap before the next element. Most gaps are short, a few are long, and
	// sets sent in steady mode have none, so the block also sees back to back
	// transactions.
	function automatic int unsigned sender_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (steady || roll < 55) begin
			return 0;
		end
		if (roll < 85) begin
			return $urandom_range(3, 1);
		end
		if (roll < 97) begin
			return $urandom_range(20, 4);
		end
		return $urandom_range(150, 30);
	endfunction

	// The receiver alternates between open and stalled stretches of random
	// length. Long open stretches let results drain at full speed; short
	// stalls land on every phase of the element walk and the search.
	initial begin
		int unsigned open_len;
		int unsigned stall_len;
		int unsigned roll;
		forever begin
			roll     = $urandom_range(99);
			open_len = (roll < 10) ? $urandom_range(400, 100) : $urandom_range(40, 1);
			roll     = $urandom_range(99);
			if (roll < 70) begin
				stall_len = $urandom_range(3, 1);
			end else if (roll < 95) begin
				stall_len = $urandom_range(20, 4);
			end else begin
				stall_len = $urandom_range(120, 30);
			end
			result_stall <= 1'b0;
			repeat (open_len) @(negedge clk);
			result_stall <= 1'b1;
			repeat (stall_len) @(negedge clk);
		end
	end

	// Drives one element from a falling edge and returns at the falling edge
	// after it was accepted. Valid stays high between elements unless a gap
	// is taken, and the payload holds while the block stalls.
	task automatic send_element(input int unsigned v, input bit last);
		int unsigned gap;
		gap = sender_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{value: VALUE_W'(v), is_last: last};
		do begin
			@(posedge clk);
		end while (item_stall);
		// A zero element that does not close the set is ignored by the block.
		if (v != 0 || last) begin
			items_sent++;
		end
		@(negedge clk);
	endtask

	// Holds the sender back until every result owed has been accepted. The
	// extra falling edge keeps valid from being lowered and raised in one step.
	task automatic drain_results();
		item_valid <= 1'b0;
		do begin
			@(negedge clk);
		end while (pending != 0);
	endtask

	// One random set. The shapes aim at different parts of the behavior:
	// plain random sets with zero elements mixed in, sets of small values whose
	// sums cover a whole range, sets built so every sum from the minimum up is
	// reachable, and sets whose total can run past the capacity of the bitset,
	// with and without a hole below it.
	task automatic send_random_set();
		int unsigned kind;
		int unsigned len;
		int unsigned v;
		int unsigned hi;
		int unsigned lo;
		int unsigned prefix;
		kind   = $urandom_range(99);
		steady = ($urandom_range(7) == 0);
		prefix = 0;
		if (kind < 5) begin
			// An empty set: only the closing mark, with a zero value.
			send_element(0, 1'b1);
		end else if (kind < 45) begin
			len = $urandom_range(6, 1);
			for (int unsigned i = 0; i < len; i++) begin
				v = ($urandom_range(9) == 0) ? 0 : $urandom_range(255, 1);
				send_element(v, i == len - 1);
			end
		end else if (kind < 65) begin
			len = $urandom_range(8, 2);
			for (int unsigned i = 0; i < len; i++) begin
				send_element($urandom_range(12, 1), i == len - 1);
			end
		end else if (kind < 85) begin
			// Each element at most one above the sum so far keeps the
			// reachable sums gap free, so the answer is the total plus one.
			len = $urandom_range(10, 2);
			for (int unsigned i = 0; i < len; i++) begin
				hi = (prefix + 1 > 255) ? 255 : prefix + 1;
				v  = $urandom_range(hi, 1);
				prefix += v;
				send_element(v, i == len - 1);
			end
		end else if (kind < 95) begin
			// Large elements only: the total can overflow, and sums just above
			// the minimum are missing.
			len = $urandom_range(22, 17);
			for (int unsigned i = 0; i < len; i++) begin
				send_element($urandom_range(255, 200), i == len - 1);
			end
		end else begin
			// Gap free growth past the capacity: the answer saturates.
			do begin
				hi = (prefix + 1 > 255) ? 255 : prefix + 1;
				lo = (prefix + 1) / 2;
				if (lo < 1) begin
					lo = 1;
				end
				if (lo > hi) begin
					lo = hi;
				end
				v = $urandom_range(hi, lo);
				prefix += v;
				send_element(v, prefix >= REACH);
			end while (prefix < REACH);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed sets. First the empty set: a lone closing mark with value
		// zero gives the answer one. Then a set whose powers of two cover
		// every sum up to 255, a zero element inside the set that must be
		// ignored, and sixteen elements of the largest value: the total
		// passes the capacity with no hole, so the answer saturates and the
		// overflow flag is raised.
		send_element(0, 1'b1);
		for (int unsigned k = 0; k < 8; k++) begin
			send_element(1 << k, 1'b0);
		end
		send_element(0, 1'b0);
		for (int unsigned k = 0; k < 16; k++) begin
			send_element(255, k == 15);
		end
		drain_results();

		// Random sets until the item count is reached. Now and then the
		// sender waits for the block to empty out completely before going on.
		while (items_sent < ITEM_GOAL) begin
			send_random_set();
			if ($urandom_range(29) == 0) begin
				drain_results();
			end
		end
		item_valid <= 1'b0;

		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (END_WAIT) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
